// ===== hw/rtl/owtr_pkg.sv =====
`default_nettype none

package owtr_pkg;

    localparam int TIMER_BITS = 20;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 20;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [4:0] bit_idx_t;

    localparam logic [7:0] CMD_SKIP    = 8'hCC;
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_READ    = 8'hBE;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRES_TIMEOUT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOT_LONG     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOT_SHORT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_READ_LOW      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONVERT_WAIT  = 3'd5;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_CONV      = 13'b0000000000010,
        ST_RD_LOW    = 13'b0000000000100,
        ST_RD_SAMPLE = 13'b0000000001000,
        ST_RD_HOLD   = 13'b0000000010000,
        ST_RD_TAIL   = 13'b0000000100000,
        ST_PRE       = 13'b0000001000000,
        ST_LOW       = 13'b0000010000000,
        ST_REC       = 13'b0000100000000,
        ST_PRES_LOW  = 13'b0001000000000,
        ST_PRES_HIGH = 13'b0010000000000,
        ST_WR_LOW    = 13'b0100000000000,
        ST_WR_HIGH   = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic [9:0]  reset_low_time;
        logic [7:0]  presence_timeout;
        logic [6:0]  slot_long_time;
        logic [3:0]  slot_short_time;
        logic [3:0]  read_low_time;
        logic [19:0] convert_wait_time;
    } owtr_cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        no_device;
        logic [15:0] temperature;
    } owtr_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/owtr_seq.sv =====
`default_nettype none

module owtr_seq
    import owtr_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        fire,
    input  wire        kind,
    input  wire        line_level,
    input  owtr_cfg_t  cfg,
    output owtr_res_t  res
);

    state_t      state_reg, state_next;
    logic        grp_reg, grp_next;
    timer_t      timer_reg, timer_next;
    bit_idx_t    bidx_reg, bidx_next;
    logic [15:0] shift_reg, shift_next;
    logic [15:0] held_reg, held_next;

    logic        finish, fail, timer_le1;
    timer_t      timer_dec;
    bit_idx_t    bidx_inc, bidx_byte;
    logic [15:0] cmd_word;
    logic        cmd_cur, cmd_nxt, cmd_first;
    timer_t      d_reset_low, d_pres, d_long, d_short, d_read_low, d_conv;

    always_comb
    begin
        d_reset_low = TIMER_BITS'(cfg.reset_low_time);
        d_pres      = TIMER_BITS'(cfg.presence_timeout);
        d_long      = TIMER_BITS'(cfg.slot_long_time);
        d_short     = TIMER_BITS'(cfg.slot_short_time);
        d_read_low  = TIMER_BITS'(cfg.read_low_time);
        d_conv      = TIMER_BITS'(cfg.convert_wait_time);
    end

    assign timer_le1 = (timer_reg <= timer_t'(1));
    assign timer_dec = timer_reg - timer_t'(1);
    assign bidx_inc  = bidx_reg + 5'd1;
    assign bidx_byte = {bidx_reg[4:3], 3'b000} + 5'd8;
    assign cmd_word  = grp_reg ? {CMD_READ, CMD_SKIP} : {CMD_CONVERT, CMD_SKIP};
    assign cmd_cur   = cmd_word[bidx_reg[3:0]];
    assign cmd_nxt   = cmd_word[bidx_inc[3:0]];
    assign cmd_first = cmd_word[0];

    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        timer_next = timer_reg;
        bidx_next  = bidx_reg;
        shift_next = shift_reg;
        held_next  = held_reg;
        finish     = 1'b0;
        fail       = 1'b0;
        if (kind)
        begin
            if (state_reg == ST_IDLE)
            begin
                bidx_next  = '0;
                shift_next = '0;
                grp_next   = 1'b0;
                state_next = ST_PRE;
                timer_next = d_short;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                end
                ST_CONV:
                begin
                    if (timer_le1)
                    begin
                        grp_next   = 1'b1;
                        state_next = ST_PRE;
                        timer_next = d_short;
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_RD_LOW:
                begin
                    if (timer_le1)
                    begin
                        state_next = ST_RD_SAMPLE;
                        timer_next = timer_t'(1);
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_RD_SAMPLE:
                begin
                    shift_next[bidx_reg[3:0]] = line_level;
                    if (line_level)
                    begin
                        state_next = ST_RD_TAIL;
                        timer_next = d_long;
                    end
                    else
                    begin
                        state_next = ST_RD_HOLD;
                        timer_next = d_pres;
                    end
                end
                ST_RD_HOLD:
                begin
                    if (line_level)
                    begin
                        state_next = ST_RD_TAIL;
                        timer_next = d_short;
                    end
                    else if (timer_le1)
                    begin
                        if (bidx_reg[3])
                            shift_next[15:8] = 8'hFF;
                        else
                            shift_next[7:0] = 8'hFF;
                        bidx_next = bidx_byte;
                        if (bidx_byte[4])
                            finish = 1'b1;
                        else
                        begin
                            state_next = ST_RD_LOW;
                            timer_next = d_read_low;
                        end
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_RD_TAIL:
                begin
                    if (timer_le1)
                    begin
                        bidx_next = bidx_inc;
                        if (bidx_inc[4])
                            finish = 1'b1;
                        else
                        begin
                            state_next = ST_RD_LOW;
                            timer_next = d_read_low;
                        end
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_PRE:
                begin
                    if (timer_le1)
                    begin
                        state_next = ST_LOW;
                        timer_next = d_reset_low;
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_LOW:
                begin
                    if (timer_le1)
                    begin
                        state_next = ST_REC;
                        timer_next = d_short;
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_REC:
                begin
                    if (timer_le1)
                    begin
                        state_next = ST_PRES_LOW;
                        timer_next = d_pres;
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_PRES_LOW:
                begin
                    if (!line_level)
                    begin
                        state_next = ST_PRES_HIGH;
                        timer_next = d_pres;
                    end
                    else if (timer_le1)
                        fail = 1'b1;
                    else
                        timer_next = timer_dec;
                end
                ST_PRES_HIGH:
                begin
                    if (line_level)
                    begin
                        bidx_next  = '0;
                        state_next = ST_WR_LOW;
                        timer_next = cmd_first ? d_short : d_long;
                    end
                    else if (timer_le1)
                        fail = 1'b1;
                    else
                        timer_next = timer_dec;
                end
                ST_WR_LOW:
                begin
                    if (timer_le1)
                    begin
                        state_next = ST_WR_HIGH;
                        timer_next = cmd_cur ? d_long : d_short;
                    end
                    else
                        timer_next = timer_dec;
                end
                ST_WR_HIGH:
                begin
                    if (timer_le1)
                    begin
                        bidx_next = bidx_inc;
                        if (!bidx_inc[4])
                        begin
                            state_next = ST_WR_LOW;
                            timer_next = cmd_nxt ? d_short : d_long;
                        end
                        else if (!grp_reg)
                        begin
                            state_next = ST_CONV;
                            timer_next = d_conv;
                        end
                        else
                        begin
                            bidx_next  = '0;
                            shift_next = '0;
                            state_next = ST_RD_LOW;
                            timer_next = d_read_low;
                        end
                    end
                    else
                        timer_next = timer_dec;
                end
                default:
                begin
                    state_next = ST_IDLE;
                    timer_next = '0;
                end
            endcase
            if (finish)
            begin
                held_next  = shift_next;
                state_next = ST_IDLE;
                timer_next = '0;
            end
            if (fail)
            begin
                state_next = ST_IDLE;
                timer_next = '0;
            end
        end
    end

    always_comb
    begin
        res.drive_low   = (state_reg == ST_RD_LOW) || (state_reg == ST_LOW)
                          || (state_reg == ST_WR_LOW);
        res.busy        = (state_next != ST_IDLE);
        res.done        = finish || fail;
        res.no_device   = fail;
        res.temperature = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            grp_reg   <= 1'b0;
            timer_reg <= '0;
            bidx_reg  <= '0;
            shift_reg <= '0;
            held_reg  <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            timer_reg <= timer_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
            held_reg  <= held_next;
        end
    end

    // A failed or finished sequence always reports done and leaves the bus idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.no_device |-> (res.done && !res.busy))
        else $error("no_device raised without done or while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> !res.busy)
        else $error("done raised while the sequence continues");

    // The sample state lasts exactly one tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !kind && state_reg == ST_RD_SAMPLE) |=> (state_reg != ST_RD_SAMPLE))
        else $error("read sample state held for more than one tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        bidx_reg <= 5'd16)
        else $error("bit index ran past the end of the word");

endmodule

`default_nettype wire

// ===== hw/rtl/onewire_temperature_reader.sv =====
// One-wire master that reads a temperature sensor. Each request on the input
// channel is either one microsecond tick, carrying the sampled line level, or a
// start command; every request produces exactly one result carrying the line
// drive, busy, done and no_device flags and the last temperature read, as signed
// sixteenths of a degree Celsius. The block takes one request per clock cycle
// while results are taken, and each request passes through an input register and
// the sequencer's single step into the result register. Timing registers are
// written through the configuration channel and are always ready; they should be
// written only while no sequence is running.
`default_nettype none

module onewire_temperature_reader
    import owtr_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire                        kind,
    input  wire                        line_level,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       no_device,
    output logic signed [15:0]         temperature,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire [CFG_DATA_BITS-1:0]    cfg_data
);

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_kind_reg, s1_line_reg;
    logic       out_valid_reg, out_valid_next;
    owtr_res_t  out_res_reg;
    owtr_cfg_t  cfg_reg, cfg_next;
    owtr_res_t  step_res;
    logic       advance, accept;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    owtr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .kind       (s1_kind_reg),
        .line_level (s1_line_reg),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RESET_LOW:    cfg_next.reset_low_time    = cfg_data[9:0];
                REG_PRES_TIMEOUT: cfg_next.presence_timeout  = cfg_data[7:0];
                REG_SLOT_LONG:    cfg_next.slot_long_time    = cfg_data[6:0];
                REG_SLOT_SHORT:   cfg_next.slot_short_time   = cfg_data[3:0];
                REG_READ_LOW:     cfg_next.read_low_time     = cfg_data[3:0];
                REG_CONVERT_WAIT: cfg_next.convert_wait_time = cfg_data[19:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.reset_low_time    <= 10'd480;
            cfg_reg.presence_timeout  <= 8'd100;
            cfg_reg.slot_long_time    <= 7'd100;
            cfg_reg.slot_short_time   <= 4'd10;
            cfg_reg.read_low_time     <= 4'd2;
            cfg_reg.convert_wait_time <= 20'd750000;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind;
            s1_line_reg <= line_level;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign out_valid   = out_valid_reg;
    assign drive_low   = out_res_reg.drive_low;
    assign busy_res    = out_res_reg.busy;
    assign done_res    = out_res_reg.done;
    assign no_device   = out_res_reg.no_device;
    assign temperature = signed'(out_res_reg.temperature);

endmodule

`default_nettype wire

// ===== sim/tb_onewire_temperature_reader.sv =====
module tb_onewire_temperature_reader;
    import owtr_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      kind;
    logic                      line_level;
    logic                      out_valid;
    logic                      out_ready;
    logic                      drive_low;
    logic                      busy_res;
    logic                      done_res;
    logic                      no_device;
    logic signed [15:0]        temperature;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Expected copy of the sequencer: timing registers and state.
    owtr_cfg_t   timing;
    state_t      seq_state;
    logic        read_pass;
    timer_t      phase_ticks;
    bit_idx_t    bit_pos;
    logic [15:0] word_shift;
    logic [15:0] word_held;
    owtr_res_t   awaited_outputs[$];

    // Behaviour of the emulated sensor for the current read.
    logic        dev_answers;
    logic        dev_lets_go;
    int          dev_pct;
    logic [1:0]  byte_stuck;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_left = 0;
    int mismatch_count = 0;

    onewire_temperature_reader u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .line_level  (line_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_low   (drive_low),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .no_device   (no_device),
        .temperature (temperature),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 300_000);
        $display("FAIL onewire_temperature_reader");
        $finish;
    end

    function automatic logic pulls_line_low(input state_t s);
        return s == ST_RD_LOW || s == ST_LOW || s == ST_WR_LOW;
    endfunction

    function automatic logic command_bit();
        logic [15:0] word;
        word = read_pass ? {CMD_READ, CMD_SKIP} : {CMD_CONVERT, CMD_SKIP};
        return word[bit_pos[3:0]];
    endfunction

    function automatic void enter_phase(input state_t s, input timer_t ticks);
        seq_state = s;
        phase_ticks = ticks;
    endfunction

    function automatic logic phase_elapsed();
        if (phase_ticks <= timer_t'(1))
            return 1'b1;
        phase_ticks = phase_ticks - timer_t'(1);
        return 1'b0;
    endfunction

    function automatic logic word_complete();
        if (bit_pos >= 5'd16)
            return 1'b1;
        enter_phase(ST_RD_LOW, timer_t'(timing.read_low_time));
        return 1'b0;
    endfunction

    task automatic advance_sequencer(input logic start, input logic level);
        owtr_res_t r;
        logic      finish;
        logic      fail;
        r = '0;
        finish = 1'b0;
        fail = 1'b0;
        if (start)
        begin
            if (seq_state == ST_IDLE)
            begin
                bit_pos = '0;
                word_shift = '0;
                read_pass = 1'b0;
                enter_phase(ST_PRE, timer_t'(timing.slot_short_time));
            end
            r.drive_low = pulls_line_low(seq_state);
        end
        else
        begin
            r.drive_low = pulls_line_low(seq_state);
            case (seq_state)
                ST_IDLE: ;
                ST_CONV:
                    if (phase_elapsed())
                    begin
                        read_pass = 1'b1;
                        enter_phase(ST_PRE, timer_t'(timing.slot_short_time));
                    end
                ST_RD_LOW:
                    if (phase_elapsed())
                        enter_phase(ST_RD_SAMPLE, timer_t'(1));
                ST_RD_SAMPLE:
                begin
                    word_shift[bit_pos[3:0]] = level;
                    if (level)
                        enter_phase(ST_RD_TAIL, timer_t'(timing.slot_long_time));
                    else
                        enter_phase(ST_RD_HOLD, timer_t'(timing.presence_timeout));
                end
                ST_RD_HOLD:
                    if (level)
                        enter_phase(ST_RD_TAIL, timer_t'(timing.slot_short_time));
                    else if (phase_ticks <= timer_t'(1))
                    begin
                        // The line was held low too long: the whole byte reads as ones.
                        if (bit_pos[3])
                            word_shift[15:8] = 8'hFF;
                        else
                            word_shift[7:0] = 8'hFF;
                        bit_pos = {1'b0, bit_pos[3], 3'b000} + 5'd8;
                        finish = word_complete();
                    end
                    else
                        phase_ticks = phase_ticks - timer_t'(1);
                ST_RD_TAIL:
                    if (phase_elapsed())
                    begin
                        bit_pos = bit_pos + 5'd1;
                        finish = word_complete();
                    end
                ST_PRE:
                    if (phase_elapsed())
                        enter_phase(ST_LOW, timer_t'(timing.reset_low_time));
                ST_LOW:
                    if (phase_elapsed())
                        enter_phase(ST_REC, timer_t'(timing.slot_short_time));
                ST_REC:
                    if (phase_elapsed())
                        enter_phase(ST_PRES_LOW, timer_t'(timing.presence_timeout));
                ST_PRES_LOW:
                    if (!level)
                        enter_phase(ST_PRES_HIGH, timer_t'(timing.presence_timeout));
                    else if (phase_ticks <= timer_t'(1))
                        fail = 1'b1;
                    else
                        phase_ticks = phase_ticks - timer_t'(1);
                ST_PRES_HIGH:
                    if (level)
                    begin
                        bit_pos = '0;
                        enter_phase(ST_WR_LOW,
                                    command_bit() ? timer_t'(timing.slot_short_time)
                                                  : timer_t'(timing.slot_long_time));
                    end
                    else if (phase_ticks <= timer_t'(1))
                        fail = 1'b1;
                    else
                        phase_ticks = phase_ticks - timer_t'(1);
                ST_WR_LOW:
                    if (phase_elapsed())
                        enter_phase(ST_WR_HIGH,
                                    command_bit() ? timer_t'(timing.slot_long_time)
                                                  : timer_t'(timing.slot_short_time));
                ST_WR_HIGH:
                    if (phase_elapsed())
                    begin
                        bit_pos = bit_pos + 5'd1;
                        if (bit_pos < 5'd16)
                            enter_phase(ST_WR_LOW,
                                        command_bit() ? timer_t'(timing.slot_short_time)
                                                      : timer_t'(timing.slot_long_time));
                        else if (!read_pass)
                            enter_phase(ST_CONV, timer_t'(timing.convert_wait_time));
                        else
                        begin
                            bit_pos = '0;
                            word_shift = '0;
                            enter_phase(ST_RD_LOW, timer_t'(timing.read_low_time));
                        end
                    end
                default:
                    enter_phase(ST_IDLE, '0);
            endcase
            if (finish)
            begin
                word_held = word_shift;
                r.done = 1'b1;
                enter_phase(ST_IDLE, '0);
            end
            if (fail)
            begin
                r.done = 1'b1;
                r.no_device = 1'b1;
                enter_phase(ST_IDLE, '0);
            end
        end
        r.busy = seq_state != ST_IDLE;
        r.temperature = word_held;
        awaited_outputs.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        owtr_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = awaited_outputs.pop_front();
                check_field("drive_low", 32'(want.drive_low), 32'(drive_low));
                check_field("busy_res", 32'(want.busy), 32'(busy_res));
                check_field("done_res", 32'(want.done), 32'(done_res));
                check_field("no_device", 32'(want.no_device), 32'(no_device));
                check_field("temperature", 32'($signed(want.temperature)), 32'(temperature));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
            out_ready <= $urandom_range(99) >= stall_pct;
    end

    task automatic send_request(input logic start, input logic level);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= start;
        line_level <= level;
        do
            @(posedge clk);
        while (!in_ready);
        advance_sequencer(start, level);
    endtask

    task automatic release_inputs();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        release_inputs();
        while (awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_RESET_LOW:    timing.reset_low_time = data[9:0];
            REG_PRES_TIMEOUT: timing.presence_timeout = data[7:0];
            REG_SLOT_LONG:    timing.slot_long_time = data[6:0];
            REG_SLOT_SHORT:   timing.slot_short_time = data[3:0];
            REG_READ_LOW:     timing.read_low_time = data[3:0];
            REG_CONVERT_WAIT: timing.convert_wait_time = data[19:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(input owtr_cfg_t c);
        wait_until_drained();
        write_register(REG_RESET_LOW, CFG_DATA_BITS'(c.reset_low_time));
        write_register(REG_PRES_TIMEOUT, CFG_DATA_BITS'(c.presence_timeout));
        write_register(REG_SLOT_LONG, CFG_DATA_BITS'(c.slot_long_time));
        write_register(REG_SLOT_SHORT, CFG_DATA_BITS'(c.slot_short_time));
        write_register(REG_READ_LOW, CFG_DATA_BITS'(c.read_low_time));
        write_register(REG_CONVERT_WAIT, CFG_DATA_BITS'(c.convert_wait_time));
        cfg_valid <= 1'b0;
    endtask

    // Phases are kept far shorter than a real bus needs so that several complete reads fit
    // in the run; zero durations are included.
    function automatic owtr_cfg_t random_timing();
        owtr_cfg_t c;
        c.reset_low_time = 10'($urandom_range(0, 12));
        c.presence_timeout = 8'($urandom_range(1, 40));
        c.slot_long_time = 7'($urandom_range(0, 2));
        c.slot_short_time = 4'($urandom_range(0, 2));
        c.read_low_time = 4'($urandom_range(0, 3));
        c.convert_wait_time = 20'($urandom_range(0, 10));
        return c;
    endfunction

    function automatic logic device_level();
        case (seq_state)
            ST_PRES_LOW:  return !(dev_answers && $urandom_range(99) < dev_pct);
            ST_PRES_HIGH: return dev_lets_go && $urandom_range(99) < dev_pct;
            ST_RD_SAMPLE: return byte_stuck[bit_pos[3]] ? 1'b0 : 1'($urandom_range(1));
            ST_RD_HOLD:   return !byte_stuck[bit_pos[3]] && $urandom_range(99) < dev_pct;
            default:      return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic run_read_sequence(input int answer_pct, input logic prompt);
        int trailing;
        dev_answers = $urandom_range(99) < answer_pct;
        dev_lets_go = prompt || $urandom_range(99) < 95;
        dev_pct = (prompt || $urandom_range(2) == 0) ? 100 : $urandom_range(30, 90);
        byte_stuck[0] = $urandom_range(99) < 12;
        byte_stuck[1] = $urandom_range(99) < 12;
        send_request(1'b1, 1'($urandom_range(1)));
        while (seq_state != ST_IDLE)
            if ($urandom_range(149) == 0)
                send_request(1'b1, 1'($urandom_range(1)));
            else
                send_request(1'b0, device_level());
        trailing = $urandom_range(3);
        repeat (trailing) send_request(1'b0, 1'($urandom_range(1)));
    endtask

    // Reset values of the timing registers; no sensor answers, so presence times out.
    task automatic test_reset_state_and_start();
        send_idle_pct = 0;
        stall_pct = 0;
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b1);
        send_request(1'b1, 1'b1);
        send_request(1'b1, 1'b0);
        repeat (20) send_request(1'b0, 1'b1);
        send_request(1'b1, 1'b1);
        send_request(1'b0, 1'b0);
        while (seq_state != ST_IDLE)
            send_request(1'b0, 1'b1);
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b1);
    endtask

    task automatic test_timing_extremes();
        owtr_cfg_t c;
        c.reset_low_time = 10'd0;
        c.presence_timeout = 8'd0;
        c.slot_long_time = 7'd0;
        c.slot_short_time = 4'd0;
        c.read_low_time = 4'd0;
        c.convert_wait_time = 20'd0;
        apply_config(c);
        run_read_sequence(100, 1'b1);
        c.presence_timeout = 8'd255;
        c.slot_long_time = 7'd127;
        c.slot_short_time = 4'd15;
        c.read_low_time = 4'd15;
        c.convert_wait_time = 20'd1000000;
        apply_config(c);
        run_read_sequence(0, 1'b0);
    endtask

    task automatic test_read_sequences(input int sender_gap_pct, input int receiver_stall_pct,
                                       input int reads);
        apply_config(random_timing());
        send_idle_pct = sender_gap_pct;
        stall_pct = receiver_stall_pct;
        for (int r = 0; r < reads; r++)
        begin
            if (r != 0 && $urandom_range(1) == 1)
                apply_config(random_timing());
            run_read_sequence(85, 1'b0);
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the block backs up.
    task automatic test_input_stall();
        send_idle_pct = 0;
        stall_pct = 0;
        apply_config(random_timing());
        @(posedge clk);
        hold_off_left = 400;
        run_read_sequence(100, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        line_level = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        timing.reset_low_time = 10'd480;
        timing.presence_timeout = 8'd100;
        timing.slot_long_time = 7'd100;
        timing.slot_short_time = 4'd10;
        timing.read_low_time = 4'd2;
        timing.convert_wait_time = 20'd750000;
        seq_state = ST_IDLE;
        read_pass = 1'b0;
        phase_ticks = '0;
        bit_pos = '0;
        word_shift = '0;
        word_held = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state_and_start();
        test_timing_extremes();
        test_read_sequences(0, 0, 1);
        test_read_sequences(80, 0, 1);
        test_read_sequences(0, 80, 1);
        test_read_sequences(11, 11, 1);
        test_input_stall();

        send_idle_pct = 0;
        stall_pct = 0;
        release_inputs();
        for (int n = 0; n < 5000 && awaited_outputs.size() != 0; n++)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (awaited_outputs.size() != 0)
        begin
            $error("%0d results never arrived", awaited_outputs.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS onewire_temperature_reader");
        else
            $display("FAIL onewire_temperature_reader");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_seq.sv
hw/rtl/onewire_temperature_reader.sv
sim/tb_onewire_temperature_reader.sv
